// ===== src/cia_pkg.sv =====
// shared types and constants for the complex integer alu
`timescale 1ns / 1ps
package cia_pkg;
   localparam int FIELD_W = 32;
   localparam int CMD_W   = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_CMP = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             eq;
      logic             a_zero;
      logic             d_zero;
      logic             neg_r;
      logic             neg_i;
   } cia_flags_type;
endpackage

// ===== src/cia_front.sv =====
// operand register, multipliers, sums and magnitude stages
`timescale 1ns / 1ps
module cia_front #(
   parameter int PW = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [2:0]             in_cmd,
   input  logic [PW-1:0]          in_ar,
   input  logic [PW-1:0]          in_ai,
   input  logic [PW-1:0]          in_br,
   input  logic [PW-1:0]          in_bi,
   output logic                   out_valid,
   output cia_pkg::cia_flags_type out_flags,
   output logic [PW-1:0]          out_rr,
   output logic [PW-1:0]          out_ri,
   output logic [PW-1:0]          out_mn_r,
   output logic [PW-1:0]          out_mn_i,
   output logic [PW-1:0]          out_md
);
   import cia_pkg::*;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic [CMD_W-1:0]     cmd1_ff, cmd2_ff, cmd3_ff;
   logic [PW-1:0]        ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic [PW-1:0]        p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic [PW-1:0]        s_r2_ff, s_i2_ff;
   logic                 eq2_ff, az2_ff, eq3_ff, az3_ff;
   logic [PW-1:0]        rr3_ff, ri3_ff, nr3_ff, ni3_ff, den3_ff;
   logic [PW-1:0]        rr3_in, ri3_in;
   cia_flags_type        flags4_ff, flags4_in;
   logic [PW-1:0]        rr4_ff, ri4_ff, mnr4_ff, mni4_ff, md4_ff;
   logic [PW-1:0]        nr3_in, ni3_in, den3_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage 1: operands
   always_ff @(posedge clock) begin
      if (advance) begin
         cmd1_ff <= in_cmd;
         ar1_ff  <= in_ar;
         ai1_ff  <= in_ai;
         br1_ff  <= in_br;
         bi1_ff  <= in_bi;
      end
   end

   // stage 2: products, sums, compare
   always_ff @(posedge clock) begin
      if (advance) begin
         cmd2_ff <= cmd1_ff;
         p0_ff   <= PW'(ar1_ff * br1_ff);
         p1_ff   <= PW'(ai1_ff * bi1_ff);
         p2_ff   <= PW'(ar1_ff * bi1_ff);
         p3_ff   <= PW'(ai1_ff * br1_ff);
         p4_ff   <= PW'(br1_ff * br1_ff);
         p5_ff   <= PW'(bi1_ff * bi1_ff);
         s_r2_ff <= (cmd1_ff == CMD_SUB) ? ar1_ff - br1_ff : ar1_ff + br1_ff;
         s_i2_ff <= (cmd1_ff == CMD_SUB) ? ai1_ff - bi1_ff : ai1_ff + bi1_ff;
         eq2_ff  <= (ar1_ff == br1_ff) && (ai1_ff == bi1_ff);
         az2_ff  <= (ar1_ff == '0) && (ai1_ff == '0);
      end
   end

   // stage 3: combine products
   always_comb begin
      nr3_in  = p0_ff + p1_ff;
      ni3_in  = p3_ff - p2_ff;
      den3_in = p4_ff + p5_ff;
      case (cmd2_ff)
         CMD_ADD, CMD_SUB: begin
            rr3_in = s_r2_ff;
            ri3_in = s_i2_ff;
         end
         CMD_MUL: begin
            rr3_in = p0_ff - p1_ff;
            ri3_in = p2_ff + p3_ff;
         end
         default: begin
            rr3_in = '0;
            ri3_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd3_ff <= cmd2_ff;
         rr3_ff  <= rr3_in;
         ri3_ff  <= ri3_in;
         nr3_ff  <= nr3_in;
         ni3_ff  <= ni3_in;
         den3_ff <= den3_in;
         eq3_ff  <= eq2_ff && (cmd2_ff == CMD_CMP);
         az3_ff  <= az2_ff;
      end
   end

   // stage 4: signs and magnitudes
   always_comb begin
      flags4_in.cmd    = cmd3_ff;
      flags4_in.eq     = eq3_ff;
      flags4_in.a_zero = az3_ff;
      flags4_in.d_zero = (den3_ff == '0);
      flags4_in.neg_r  = nr3_ff[PW-1] ^ den3_ff[PW-1];
      flags4_in.neg_i  = ni3_ff[PW-1] ^ den3_ff[PW-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         flags4_ff <= flags4_in;
         rr4_ff    <= rr3_ff;
         ri4_ff    <= ri3_ff;
         mnr4_ff   <= nr3_ff[PW-1] ? -nr3_ff : nr3_ff;
         mni4_ff   <= ni3_ff[PW-1] ? -ni3_ff : ni3_ff;
         md4_ff    <= den3_ff[PW-1] ? -den3_ff : den3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_flags = flags4_ff;
   assign out_rr    = rr4_ff;
   assign out_ri    = ri4_ff;
   assign out_mn_r  = mnr4_ff;
   assign out_mn_i  = mni4_ff;
   assign out_md    = md4_ff;
endmodule

// ===== src/cia_div_pipe.sv =====
// one quotient bit per stage restoring divider for both result parts
`timescale 1ns / 1ps
module cia_div_pipe #(
   parameter int PW = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  cia_pkg::cia_flags_type in_flags,
   input  logic [PW-1:0]          in_rr,
   input  logic [PW-1:0]          in_ri,
   input  logic [PW-1:0]          in_mn_r,
   input  logic [PW-1:0]          in_mn_i,
   input  logic [PW-1:0]          in_md,
   output logic                   out_valid,
   output cia_pkg::cia_flags_type out_flags,
   output logic [PW-1:0]          out_rr,
   output logic [PW-1:0]          out_ri,
   output logic [PW-1:0]          out_q_r,
   output logic [PW-1:0]          out_q_i
);
   import cia_pkg::*;

   logic          v_ff   [1:PW];
   cia_flags_type fl_ff  [1:PW];
   logic [PW-1:0] rr_ff  [1:PW];
   logic [PW-1:0] ri_ff  [1:PW];
   logic [PW-1:0] md_ff  [1:PW];
   logic [PW-1:0] nr_ff  [1:PW];
   logic [PW-1:0] ni_ff  [1:PW];
   logic [PW-1:0] remr_ff[1:PW];
   logic [PW-1:0] remi_ff[1:PW];

   for (genvar k = 0; k < PW; k++) begin : g_stage
      logic          v_s;
      cia_flags_type fl_s;
      logic [PW-1:0] rr_s, ri_s, md_s, nr_s, ni_s, remr_s, remi_s;
      logic [PW:0]   sh_r, sh_i;
      logic          ge_r, ge_i;
      logic [PW-1:0] nr_in, ni_in, remr_in, remi_in;

      if (k == 0) begin : g_first
         assign v_s    = in_valid;
         assign fl_s   = in_flags;
         assign rr_s   = in_rr;
         assign ri_s   = in_ri;
         assign md_s   = in_md;
         assign nr_s   = in_mn_r;
         assign ni_s   = in_mn_i;
         assign remr_s = '0;
         assign remi_s = '0;
      end else begin : g_next
         assign v_s    = v_ff[k];
         assign fl_s   = fl_ff[k];
         assign rr_s   = rr_ff[k];
         assign ri_s   = ri_ff[k];
         assign md_s   = md_ff[k];
         assign nr_s   = nr_ff[k];
         assign ni_s   = ni_ff[k];
         assign remr_s = remr_ff[k];
         assign remi_s = remi_ff[k];
      end

      always_comb begin
         sh_r    = {remr_s, nr_s[PW-1]};
         sh_i    = {remi_s, ni_s[PW-1]};
         ge_r    = sh_r >= {1'b0, md_s};
         ge_i    = sh_i >= {1'b0, md_s};
         remr_in = ge_r ? PW'(sh_r - {1'b0, md_s}) : sh_r[PW-1:0];
         remi_in = ge_i ? PW'(sh_i - {1'b0, md_s}) : sh_i[PW-1:0];
         nr_in   = {nr_s[PW-2:0], ge_r};
         ni_in   = {ni_s[PW-2:0], ge_i};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (advance) begin
            v_ff[k+1] <= v_s;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            fl_ff[k+1]   <= fl_s;
            rr_ff[k+1]   <= rr_s;
            ri_ff[k+1]   <= ri_s;
            md_ff[k+1]   <= md_s;
            nr_ff[k+1]   <= nr_in;
            ni_ff[k+1]   <= ni_in;
            remr_ff[k+1] <= remr_in;
            remi_ff[k+1] <= remi_in;
         end
      end
   end

   assign out_valid = v_ff[PW];
   assign out_flags = fl_ff[PW];
   assign out_rr    = rr_ff[PW];
   assign out_ri    = ri_ff[PW];
   assign out_q_r   = nr_ff[PW];
   assign out_q_i   = ni_ff[PW];
endmodule

// ===== src/complex_integer_alu_core.sv =====
// a request passes the front stages, the divider stages and the output register before rsp_tvalid
// throughput: one transaction per cycle while the output is not stalled, set by the one-bit-per-stage divider pipeline
// the whole pipeline holds while the output register is full and rsp_tready is low
// synchronous active-high reset clears all valid bits; payload registers are not reset
`timescale 1ns / 1ps
module complex_integer_alu_core #(
   parameter int PART_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // a_real, a_imag, b_real, b_imag
   input  logic [2:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // res_real, res_imag
   output logic [1:0]   rsp_tuser   // is_equal, div_error
);
   import cia_pkg::*;

   localparam int PW = PART_WIDTH;

   logic                 advance;
   logic [PW-1:0]        ar, ai, br, bi;
   logic                 f_valid, d_valid;
   cia_flags_type        f_flags, d_flags;
   logic [PW-1:0]        f_rr, f_ri, f_mnr, f_mni, f_md;
   logic [PW-1:0]        d_rr, d_ri, d_qr, d_qi;
   logic [PW-1:0]        res_r, res_i;
   logic                 err;
   logic                 out_valid_ff;
   logic [FIELD_W-1:0]   out_r_ff, out_i_ff, out_r_in, out_i_in;
   logic                 out_eq_ff, out_err_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   if (PW <= FIELD_W) begin : g_narrow
      assign ar       = req_tdata[PW-1:0];
      assign ai       = req_tdata[32+PW-1:32];
      assign br       = req_tdata[64+PW-1:64];
      assign bi       = req_tdata[96+PW-1:96];
      assign out_r_in = FIELD_W'(signed'(res_r));
      assign out_i_in = FIELD_W'(signed'(res_i));
   end else begin : g_wide
      assign ar       = {{(PW-FIELD_W){1'b0}}, req_tdata[31:0]};
      assign ai       = {{(PW-FIELD_W){1'b0}}, req_tdata[63:32]};
      assign br       = {{(PW-FIELD_W){1'b0}}, req_tdata[95:64]};
      assign bi       = {{(PW-FIELD_W){1'b0}}, req_tdata[127:96]};
      assign out_r_in = res_r[FIELD_W-1:0];
      assign out_i_in = res_i[FIELD_W-1:0];
   end

   cia_front #(.PW(PW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_cmd    (req_tuser),
      .in_ar     (ar),
      .in_ai     (ai),
      .in_br     (br),
      .in_bi     (bi),
      .out_valid (f_valid),
      .out_flags (f_flags),
      .out_rr    (f_rr),
      .out_ri    (f_ri),
      .out_mn_r  (f_mnr),
      .out_mn_i  (f_mni),
      .out_md    (f_md)
   );

   cia_div_pipe #(.PW(PW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f_valid),
      .in_flags  (f_flags),
      .in_rr     (f_rr),
      .in_ri     (f_ri),
      .in_mn_r   (f_mnr),
      .in_mn_i   (f_mni),
      .in_md     (f_md),
      .out_valid (d_valid),
      .out_flags (d_flags),
      .out_rr    (d_rr),
      .out_ri    (d_ri),
      .out_q_r   (d_qr),
      .out_q_i   (d_qi)
   );

   always_comb begin
      res_r = d_rr;
      res_i = d_ri;
      err   = 1'b0;
      if (d_flags.cmd == CMD_DIV) begin
         if (d_flags.a_zero) begin
            res_r = '0;
            res_i = '0;
         end else if (d_flags.d_zero) begin
            res_r = '0;
            res_i = '0;
            err   = 1'b1;
         end else begin
            res_r = d_flags.neg_r ? -d_qr : d_qr;
            res_i = d_flags.neg_i ? -d_qi : d_qi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_r_ff   <= out_r_in;
         out_i_ff   <= out_i_in;
         out_eq_ff  <= d_flags.eq;
         out_err_ff <= err;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_i_ff, out_r_ff};
   assign rsp_tuser  = {out_err_ff, out_eq_ff};

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("is_equal and div_error both set");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tdata == '0))
      else $error("div_error with nonzero result");

   a_eq_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("compare with nonzero result");

   a_ready : assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow output stall");
endmodule

// ===== sim/complex_integer_alu_core_tb.sv =====
// self-checking testbench for the complex integer alu core: directed and random stream traffic
`timescale 1ns / 1ps
module complex_integer_alu_core_tb;
   import cia_pkg::*;

   typedef struct {
      logic [31:0] res_real;
      logic [31:0] res_imag;
      logic        is_equal;
      logic        div_error;
   } alu_result_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [63:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   alu_result_type pending_results[$];
   int             mismatch_count;
   int             send_idle_pct;
   int             recv_stall_pct;

   complex_integer_alu_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // signed division truncated toward zero, most negative over -1 wraps
   function automatic logic [31:0] quotient_trunc(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag_n;
      logic [31:0] mag_d;
      logic [31:0] q;
      mag_n = num[31] ? -num : num;
      mag_d = den[31] ? -den : den;
      q = mag_n / mag_d;
      return (num[31] != den[31]) ? -q : q;
   endfunction

   function automatic alu_result_type predict_complex_op(logic [2:0] cmd, logic [31:0] ar,
         logic [31:0] ai, logic [31:0] br, logic [31:0] bi);
      alu_result_type r;
      logic [31:0] den;
      r = '{32'd0, 32'd0, 1'b0, 1'b0};
      case (cmd)
         CMD_ADD: begin
            r.res_real = ar + br;
            r.res_imag = ai + bi;
         end
         CMD_SUB: begin
            r.res_real = ar - br;
            r.res_imag = ai - bi;
         end
         CMD_MUL: begin
            r.res_real = ar * br - ai * bi;
            r.res_imag = ar * bi + ai * br;
         end
         CMD_DIV: begin
            if (ar != 0 || ai != 0) begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  r.div_error = 1'b1;
               end else begin
                  r.res_real = quotient_trunc(ar * br + ai * bi, den);
                  r.res_imag = quotient_trunc(ai * br - ar * bi, den);
               end
            end
         end
         CMD_CMP: r.is_equal = (ar == br) && (ai == bi);
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_operands(logic [2:0] cmd, logic [31:0] ar, logic [31:0] ai,
         logic [31:0] br, logic [31:0] bi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {bi, br, ai, ar};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_complex_op(cmd, ar, ai, br, bi));
   endtask

   function automatic logic [31:0] pick_part();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'd0;
         3: return 32'($signed($urandom_range(0, 8)) - 4);
         4: return 32'($urandom_range(0, 65535)) - 32'd32768;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_extremes();
      send_operands(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff);
      send_operands(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'hffff_ffff);
      send_operands(CMD_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_operands(CMD_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_operands(CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
   endtask

   task automatic test_divide_cases();
      send_operands(CMD_DIV, 32'd0, 32'd0, 32'd0, 32'd0);          // zero dividend
      send_operands(CMD_DIV, 32'd0, 32'd0, 32'd5, 32'd7);
      send_operands(CMD_DIV, 32'd3, 32'd0, 32'd0, 32'd0);          // zero divisor
      send_operands(CMD_DIV, 32'd3, 32'd4, 32'h0001_0000, 32'd0);  // wrapped zero denominator
      send_operands(CMD_DIV, 32'h8000_0000, 32'd0, 32'hffff_ffff, 32'd0); // quotient overflow
      send_operands(CMD_DIV, 32'd100, 32'hffff_ff9c, 32'd3, 32'hffff_fffe);
      send_operands(CMD_DIV, 32'hffff_fff9, 32'd7, 32'd2, 32'd0);
      send_operands(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'd1);
   endtask

   task automatic test_compare_and_unknown();
      send_operands(CMD_CMP, 32'd9, 32'hffff_fff0, 32'd9, 32'hffff_fff0);
      send_operands(CMD_CMP, 32'd9, 32'hffff_fff0, 32'd9, 32'hffff_fff1);
      send_operands(CMD_CMP, 32'd9, 32'd1, 32'd8, 32'd1);
      send_operands(3'd5, 32'd1, 32'd2, 32'd3, 32'd4);
      send_operands(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_operands(3'd7, 32'h8000_0000, 32'd1, 32'd2, 32'd3);
   endtask

   task automatic test_random_ops(int count);
      logic [2:0]  cmd;
      logic [31:0] ar;
      logic [31:0] ai;
      logic [31:0] br;
      logic [31:0] bi;
      repeat (count) begin
         cmd = ($urandom_range(15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         ar = pick_part();
         ai = pick_part();
         br = pick_part();
         bi = pick_part();
         if (cmd == CMD_CMP && $urandom_range(1)) begin
            br = ar;
            if ($urandom_range(1)) bi = ai;
         end
         send_operands(cmd, ar, ai, br, bi);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      alu_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected transaction %h %b", rsp_tdata, rsp_tuser);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[31:0] !== want.res_real || rsp_tdata[63:32] !== want.res_imag ||
                     rsp_tuser[0] !== want.is_equal || rsp_tuser[1] !== want.div_error) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected re %h im %h eq %b err %b, %s",
                        want.res_real, want.res_imag, want.is_equal, want.div_error,
                        $sformatf("got re %h im %h eq %b err %b",
                           rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0], rsp_tuser[1]));
               end
            end
         end
      end
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      mismatch_count = 0;
      send_idle_pct  = 34;
      recv_stall_pct = 49;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_divide_cases();
      test_compare_and_unknown();
      test_random_ops(520);
      send_idle_pct  = 49;
      recv_stall_pct = 34;
      test_random_ops(520);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_ops(540);
      drain_results();
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
